FILE: rtl/core/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

   // Field widths of the stream items.
   localparam int PIXEL_W = 8;
   localparam int ROW_W   = 12;
   localparam int OUTCOL_W = 11;
   localparam int SUM_W   = 12;
   localparam int CSR_W   = 12;

   // Default line store depth and register reset values.
   localparam int MAX_WIDTH_DEFAULT    = 2048;
   localparam logic [CSR_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 12'd480;

   // Register indexes on the configuration port.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // floor(s / 9) == (s * RECIP_NINE) >> RECIP_SHIFT for every s up to 2295.
   localparam logic [12:0] RECIP_NINE  = 13'd7282;
   localparam int          RECIP_SHIFT = 16;

   // Border replication flags of one completed window.
   typedef struct packed {
      logic row_pre;   // Window center is row 1: row 0 copies it first.
      logic row_post;  // Window center is row height-2: last row copies it.
      logic col_pre;   // Window center is column 1: column 0 copies it first.
      logic col_post;  // Window center is column width-2: last column copies it.
   } bb3_flags_type;

endpackage

`default_nettype wire

FILE: rtl/core/bb3_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bb3_line_mem #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/bb3_window.sv
`timescale 1ns / 1ps
`default_nettype none

module bb3_window
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Pixel entering, with its position; the line store read is issued alongside.
   input  wire logic                              load,
   input  wire logic [PIXEL_W-1:0]                load_pixel,
   input  wire logic [ROW_W-1:0]                  load_row,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]      load_col,
   output logic                                   ready,
   // Frame geometry.
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
   input  wire logic [ROW_W-1:0]                  height,
   // Line store read data and write back.
   input  wire logic [2*PIXEL_W-1:0]              mem_rd_data,
   output logic                                   mem_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]           mem_wr_addr,
   output logic [2*PIXEL_W-1:0]                   mem_wr_data,
   // Completed window toward the result expander.
   output logic                                   push,
   input  wire logic                              push_ready,
   output logic [SUM_W-1:0]                       push_sum,
   output logic [ROW_W-1:0]                       push_row,
   output logic [$clog2(MAX_WIDTH)-1:0]           push_col,
   output bb3_flags_type                          push_flags
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int EW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (CW + 1 > ROW_W) ? CW + 1 : ROW_W;

   logic                 valid_ff, valid_in;
   logic [PIXEL_W-1:0]   pix_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [CW-1:0]        col_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [2*PIXEL_W-1:0] fwd_data_ff;
   logic [PIXEL_W-1:0]   win_ff [6];
   logic [PIXEL_W-1:0]   upper, lower;
   logic [2*PIXEL_W-1:0] entry;
   logic                 has_window;
   logic                 fire;
   logic [SUM_W-1:0]     sum;

   // A write back at the same edge as the read of the same entry is forwarded.
   assign entry = fwd_hit_ff ? fwd_data_ff : mem_rd_data;
   assign upper = entry[2*PIXEL_W-1:PIXEL_W];
   assign lower = entry[PIXEL_W-1:0];

   // Sum of the nine window pixels.
   always_comb begin
      sum = SUM_W'(upper) + SUM_W'(lower) + SUM_W'(pix_ff);
      for (int k = 0; k < 6; k++) begin
         sum = sum + SUM_W'(win_ff[k]);
      end
   end

   assign has_window = (row_ff >= ROW_W'(2)) && (col_ff >= CW'(2)) &&
                       (width_eff >= EW'(3)) && (height >= ROW_W'(3));
   assign fire  = valid_ff && (!has_window || push_ready);
   assign ready = !valid_ff || fire;

   assign fwd_hit_in = fire && (col_ff == load_col);
   assign valid_in   = load ? 1'b1 : (fire ? 1'b0 : valid_ff);

   // Stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff      <= load_pixel;
         row_ff      <= load_row;
         col_ff      <= load_col;
         fwd_data_ff <= {lower, pix_ff};
      end
   end

   // Window columns shift left as each pixel completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else if (fire) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k] <= win_ff[k+3];
         end
         win_ff[3] <= upper;
         win_ff[4] <= lower;
         win_ff[5] <= pix_ff;
      end
   end

   // Rows shift down by one in the line store entry.
   assign mem_wr_en   = fire;
   assign mem_wr_addr = col_ff;
   assign mem_wr_data = {lower, pix_ff};

   assign push       = valid_ff && has_window && push_ready;
   assign push_sum   = sum;
   assign push_row   = row_ff - ROW_W'(1);
   assign push_col   = col_ff - CW'(1);

   // The center sits one row and one column behind the pixel that completes it.
   assign push_flags.row_pre  = (row_ff == ROW_W'(2));
   assign push_flags.row_post = ((ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1) ==
                                 (ROW_W + 1)'(height));
   assign push_flags.col_pre  = (col_ff == CW'(2));
   assign push_flags.col_post = (CMPW'(col_ff) + CMPW'(1) == CMPW'(width_eff));

endmodule

`default_nettype wire

FILE: rtl/core/bb3_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module bb3_emit
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
   input  wire logic [ROW_W-1:0]                  height,
   // Completed window.
   input  wire logic                              push,
   output logic                                   push_ready,
   input  wire logic [SUM_W-1:0]                  push_sum,
   input  wire logic [ROW_W-1:0]                  push_row,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]      push_col,
   input  wire bb3_flags_type                     push_flags,
   // Result stream.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [PIXEL_W-1:0]                     rsp_value,
   output logic [ROW_W-1:0]                       rsp_row,
   output logic [OUTCOL_W-1:0]                    rsp_col,
   output logic                                   rsp_last,
   output logic                                   rsp_done
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int EW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (CW + 1 > ROW_W) ? CW + 1 : ROW_W;
   localparam int PW   = SUM_W + 13;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_MAIN,
      PH_POST
   } phase_type;

   logic            valid_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [ROW_W-1:0] row_ff;
   logic [CW-1:0]    col_ff;
   bb3_flags_type    flags_ff;
   phase_type        rph_ff, cph_ff;

   logic                rsp_valid_ff;
   logic [PIXEL_W-1:0]  value_ff;
   logic [ROW_W-1:0]    orow_ff;
   logic [OUTCOL_W-1:0] ocol_ff;
   logic                last_ff, done_ff;

   logic             out_load;
   logic             row_last, col_last, is_last;
   logic [ROW_W-1:0] row_val;
   logic [CW-1:0]    col_val;
   logic [CMPW-1:0]  col_ext;
   logic [PW-1:0]    product;
   logic             done_val;
   phase_type        rph_next, cph_next, col_start;

   assign out_load   = valid_ff && (!rsp_valid_ff || rsp_ready);
   assign push_ready = !valid_ff || (out_load && is_last);

   // Coordinates of the current copy.
   always_comb begin
      unique case (rph_ff)
         PH_PRE:  row_val = '0;
         PH_MAIN: row_val = row_ff;
         PH_POST: row_val = height - ROW_W'(1);
         default: row_val = row_ff;
      endcase
      unique case (cph_ff)
         PH_PRE:  col_val = '0;
         PH_MAIN: col_val = col_ff;
         PH_POST: col_val = CW'(width_eff - EW'(1));
         default: col_val = col_ff;
      endcase
   end

   assign row_last = (rph_ff == PH_POST) || ((rph_ff == PH_MAIN) && !flags_ff.row_post);
   assign col_last = (cph_ff == PH_POST) || ((cph_ff == PH_MAIN) && !flags_ff.col_post);
   assign is_last  = row_last && col_last;

   assign rph_next  = (rph_ff == PH_PRE) ? PH_MAIN : PH_POST;
   assign cph_next  = (cph_ff == PH_PRE) ? PH_MAIN : PH_POST;
   assign col_start = flags_ff.col_pre ? PH_PRE : PH_MAIN;

   assign col_ext  = CMPW'(col_val);
   assign done_val = ((ROW_W + 1)'(row_val) + (ROW_W + 1)'(1) == (ROW_W + 1)'(height)) &&
                     (col_ext + CMPW'(1) == CMPW'(width_eff));

   // Division by nine through the reciprocal.
   assign product = PW'(sum_ff) * PW'(RECIP_NINE);

   // Expander control: walks rows, then columns, of the copy list.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rph_ff   <= PH_MAIN;
         cph_ff   <= PH_MAIN;
      end else if (push) begin
         valid_ff <= 1'b1;
         rph_ff   <= push_flags.row_pre ? PH_PRE : PH_MAIN;
         cph_ff   <= push_flags.col_pre ? PH_PRE : PH_MAIN;
      end else if (out_load) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else if (col_last) begin
            rph_ff <= rph_next;
            cph_ff <= col_start;
         end else begin
            cph_ff <= cph_next;
         end
      end
   end

   // Window payload.
   always_ff @(posedge clock) begin
      if (push) begin
         sum_ff   <= push_sum;
         row_ff   <= push_row;
         col_ff   <= push_col;
         flags_ff <= push_flags;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         value_ff <= product[RECIP_SHIFT+PIXEL_W-1:RECIP_SHIFT];
         orow_ff  <= row_val;
         ocol_ff  <= col_ext[OUTCOL_W-1:0];
         last_ff  <= is_last;
         done_ff  <= done_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = value_ff;
   assign rsp_row   = orow_ff;
   assign rsp_col   = ocol_ff;
   assign rsp_last  = last_ff;
   assign rsp_done  = done_ff;

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3_replicate_border_core.sv
`timescale 1ns / 1ps
`default_nettype none

// 3x3 box blur with replicated border. Pixels enter in raster order, one per
// cycle while the window stage is not stalled; a pixel that completes an
// interior window gives floor(sum / 9) of its nine neighbors, sent once for
// every output coordinate that clamps to that window center, with the
// coordinates, tlast on the final copy and tuser on the result for the frame's
// bottom-right pixel. An item that yields n results (up to nine on a corner,
// three on an edge) holds the window stage until its last copy is loaded into
// the single result register that the copy expander feeds. The two line stores
// share one MAX_WIDTH x 16 memory that is read when a pixel is accepted and
// written back when that pixel leaves the window stage; entries are not
// cleared after reset, so each frame must start with frame_start (or after a
// completed frame) and the width must not grow inside a frame. Widths above
// MAX_WIDTH are clamped. Configure only while the block is idle.
module box_blur_3x3_replicate_border_core
   import bb3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Pixel stream.
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,  // [7:0] pixel
   input  wire logic              req_tuser,  // [0] frame_start
   // Result stream.
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,  // [7:0] value, [19:8] out_row, [30:20] out_col
   output logic                   rsp_tlast,  // last
   output logic                   rsp_tuser,  // [0] frame_done
   // Configuration.
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int EW   = $clog2(MAX_WIDTH + 1);
   localparam int CMPW = (CW + 1 > ROW_W) ? CW + 1 : ROW_W;

   logic [CSR_W-1:0] width_ff, height_ff;
   logic [EW-1:0]    width_eff;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic [CW-1:0]    col_ff, col_in, col_cur;
   logic             accept;

   logic                 mem_wr_en;
   logic [CW-1:0]        mem_wr_addr;
   logic [2*PIXEL_W-1:0] mem_wr_data, mem_rd_data;

   logic                push, push_ready;
   logic [SUM_W-1:0]    push_sum;
   logic [ROW_W-1:0]    push_row;
   logic [CW-1:0]       push_col;
   bb3_flags_type       push_flags;

   logic [PIXEL_W-1:0]  out_value;
   logic [ROW_W-1:0]    out_row;
   logic [OUTCOL_W-1:0] out_col;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   assign width_eff = (CMPW'(width_ff) > CMPW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_ff);

   // Raster position of the accepted pixel and of the one after it.
   assign accept  = req_tvalid && req_tready;
   assign row_cur = req_tuser ? '0 : row_ff;
   assign col_cur = req_tuser ? '0 : col_ff;

   always_comb begin
      if (CMPW'(col_cur) + CMPW'(1) >= CMPW'(width_eff)) begin
         col_in = '0;
         if ((ROW_W + 1)'(row_cur) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(height_ff)) begin
            row_in = '0;
         end else begin
            row_in = row_cur + ROW_W'(1);
         end
      end else begin
         col_in = col_cur + CW'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Line stores: upper row in the high byte, lower row in the low byte.
   bb3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (2 * PIXEL_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // Window assembly and sum.
   bb3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_pixel  (req_tdata),
      .load_row    (row_cur),
      .load_col    (col_cur),
      .ready       (req_tready),
      .width_eff   (width_eff),
      .height      (height_ff),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .push        (push),
      .push_ready  (push_ready),
      .push_sum    (push_sum),
      .push_row    (push_row),
      .push_col    (push_col),
      .push_flags  (push_flags)
   );

   // Mean and border copies.
   bb3_emit #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .width_eff  (width_eff),
      .height     (height_ff),
      .push       (push),
      .push_ready (push_ready),
      .push_sum   (push_sum),
      .push_row   (push_row),
      .push_col   (push_col),
      .push_flags (push_flags),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (out_value),
      .rsp_row    (out_row),
      .rsp_col    (out_col),
      .rsp_last   (rsp_tlast),
      .rsp_done   (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, out_col, out_row, out_value};

endmodule

`default_nettype wire

FILE: verif/tb_box_blur_3x3_replicate_border_core.sv
`timescale 1ns / 1ps

module tb_box_blur_3x3_replicate_border_core;
   import bb3_pkg::*;

   localparam int LINE_DEPTH       = MAX_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int LONG_HOLD_CYCLES = 300;

   // One blurred output pixel as the block should send it.
   typedef struct packed {
      logic [7:0]  value;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        last;
      logic        frame_done;
   } blur_result_type;

   // Mirror of the blur datapath plus the queue of blurred pixels still owed.
   class blur_scoreboard;
      bit [7:0]        upper_line [LINE_DEPTH];
      bit [7:0]        lower_line [LINE_DEPTH];
      bit [7:0]        window [6];
      int unsigned     width_reg;
      int unsigned     height_reg;
      int unsigned     row_pos;
      int unsigned     col_pos;
      blur_result_type blurred_q[$];
      int unsigned     mismatches;
      int unsigned     results_checked;
      int unsigned     pixels_seen;

      // Line stores and window start at zero, as the two-state arrays already are.
      function new();
         width_reg       = 32'(WIDTH_RESET);
         height_reg      = 32'(HEIGHT_RESET);
         row_pos         = 0;
         col_pos         = 0;
         mismatches      = 0;
         results_checked = 0;
         pixels_seen     = 0;
      endfunction

      function void set_reg(logic idx, logic [CSR_W-1:0] v);
         if (idx == CSR_IMAGE_WIDTH) begin
            width_reg = 32'(v);
         end else begin
            height_reg = 32'(v);
         end
      endfunction

      function int pending();
         return blurred_q.size();
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      // Advance the model by one accepted pixel and queue the copies it causes.
      function void note_pixel(logic [7:0] px, logic fs);
         int unsigned     w;
         int unsigned     h;
         int unsigned     r;
         int unsigned     c;
         int unsigned     sum;
         int unsigned     nr;
         int unsigned     nc;
         int unsigned     i;
         int unsigned     j;
         int unsigned     rows [3];
         int unsigned     cols [3];
         bit [7:0]        above2;
         bit [7:0]        above1;
         bit [7:0]        blurred;
         blur_result_type res;
         w = (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
         h = height_reg;
         pixels_seen++;
         if (fs) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = (col_pos >= LINE_DEPTH) ? 0 : col_pos;

         // Read both line stores at this column, then push the column down.
         above2 = upper_line[c];
         above1 = lower_line[c];
         upper_line[c] = above1;
         lower_line[c] = px;

         sum = 32'(above2) + 32'(above1) + 32'(px);
         for (i = 0; i < 6; i++) begin
            sum += 32'(window[i]);
         end
         blurred = 8'(sum / 9);
         for (i = 0; i < 3; i++) begin
            window[i] = window[i + 3];
         end
         window[3] = above2;
         window[4] = above1;
         window[5] = px;

         // A complete window centered on (r-1, c-1) is copied to every border
         // coordinate that clamps to it, rows first, then columns.
         if (r >= 2 && c >= 2 && w >= 3 && h >= 3) begin
            nr = 0;
            nc = 0;
            if (r - 1 == 1) begin
               rows[nr] = 0;
               nr++;
            end
            rows[nr] = r - 1;
            nr++;
            if (r - 1 == h - 2) begin
               rows[nr] = h - 1;
               nr++;
            end
            if (c - 1 == 1) begin
               cols[nc] = 0;
               nc++;
            end
            cols[nc] = c - 1;
            nc++;
            if (c - 1 == w - 2) begin
               cols[nc] = w - 1;
               nc++;
            end
            for (i = 0; i < nr; i++) begin
               for (j = 0; j < nc; j++) begin
                  res.value      = blurred;
                  res.out_row    = rows[i][11:0];
                  res.out_col    = cols[j][10:0];
                  res.last       = (i == nr - 1) && (j == nc - 1);
                  res.frame_done = (rows[i] == h - 1) && (cols[j] == w - 1);
                  blurred_q.push_back(res);
               end
            end
         end

         // Raster counters wrap on the row end and on the frame end.
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
            row_pos = r;
         end
      endfunction

      // Compare one accepted result transfer with the oldest blurred pixel owed.
      task check_result(logic [31:0] data, logic last, logic done);
         blur_result_type want;
         results_checked++;
         if (blurred_q.size() == 0) begin
            flag_mismatch($sformatf("result with nothing owed: value %0d row %0d col %0d",
                                    data[7:0], data[19:8], data[30:20]));
            return;
         end
         want = blurred_q.pop_front();
         if (data[7:0] !== want.value) begin
            flag_mismatch($sformatf("value %0d, wanted %0d at row %0d col %0d",
                                    data[7:0], want.value, want.out_row, want.out_col));
         end
         if (data[19:8] !== want.out_row) begin
            flag_mismatch($sformatf("out_row %0d, wanted %0d", data[19:8], want.out_row));
         end
         if (data[30:20] !== want.out_col) begin
            flag_mismatch($sformatf("out_col %0d, wanted %0d", data[30:20], want.out_col));
         end
         if (last !== want.last) begin
            flag_mismatch($sformatf("tlast %b, wanted %b at row %0d col %0d",
                                    last, want.last, want.out_row, want.out_col));
         end
         if (done !== want.frame_done) begin
            flag_mismatch($sformatf("frame_done %b, wanted %b at row %0d col %0d",
                                    done, want.frame_done, want.out_row, want.out_col));
         end
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'd0;   // [7:0] pixel
   logic              req_tuser = 1'b0;   // [0] frame_start
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;          // [7:0] value, [19:8] out_row, [30:20] out_col
   logic              rsp_tlast;
   logic              rsp_tuser;          // [0] frame_done
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0]  csr_wdata = '0;

   bit                idle_on = 1'b1;
   bit                long_hold_req = 1'b0;
   int unsigned       quiet_cycles = 0;
   int unsigned       geometries = 0;
   blur_scoreboard    blur_check = new();

   box_blur_3x3_replicate_border_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample every transfer and register write at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) begin
            blur_check.set_reg(csr_index, csr_wdata);
         end
         if (req_tvalid && req_tready) begin
            blur_check.note_pixel(req_tdata, req_tuser);
         end
         if (rsp_tvalid && rsp_tready) begin
            blur_check.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         end
      end
   end

   // End the run if neither side completes a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results still owed",
                  quiet_cycles, blur_check.pending());
         $display("[box_blur_3x3_replicate_border_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: ready most of the time, random stalls, one long hold on request.
   initial begin
      forever begin
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Mostly random pixels, with the two extremes showing up often.
   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Offer one pixel and hold it until the transfer, then maybe idle a while.
   task automatic send_pixel(input logic [7:0] px, input logic fs);
      req_tdata  <= px;
      req_tuser  <= fs;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(0, 255));
         req_tuser  <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // A run of raster pixels; stray frame starts break frames now and then.
   task automatic send_run(input int unsigned count, input bit start_first,
                           input bit stray_starts);
      int unsigned i;
      logic        fs;
      for (i = 0; i < count; i++) begin
         fs = (i == 0 && start_first) ||
              (stray_starts && i != 0 && $urandom_range(0, 59) == 0);
         send_pixel(pick_pixel(), fs);
      end
   endtask

   // Stop offering, wait until every owed result has arrived, then let the block settle.
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blur_check.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reprogram the frame geometry while the block is idle.
   task automatic change_setting(input int unsigned w, input int unsigned h);
      drain_pipeline();
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w[CSR_W-1:0];
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      geometries++;
   endtask

   initial begin
      logic [71:0] low_sum_frame;
      int unsigned i;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned phase_idx;
      int unsigned random_items;
      low_sum_frame = {8'd0, 8'd5, 8'd2, 8'd0, 8'd4, 8'd0, 8'd3, 8'd2, 8'd1};
      phase_idx     = 0;
      random_items  = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: the first pixels of a 640-wide frame give no window yet.
      geometries++;
      send_run(4, 1'b1, 1'b0);

      // Smallest frame: every pixel of a 3x3 frame is a border copy of the center.
      change_setting(3, 3);
      for (i = 0; i < 9; i++) begin
         send_pixel(8'hFF, i == 0);
      end
      // Next frame follows on the counter wrap alone; sum of 8 floors to zero.
      for (i = 0; i < 9; i++) begin
         send_pixel((i == 4) ? 8'd8 : 8'd0, 1'b0);
      end
      // A stray pixel, then a frame start cuts that frame short; sum 17 gives 1.
      send_pixel(8'd200, 1'b0);
      for (i = 0; i < 9; i++) begin
         send_pixel(low_sum_frame[i*8 +: 8], i == 0);
      end

      // Geometries too small for any interior: counters run, nothing comes out.
      change_setting(2, 9);
      send_run(12, 1'b1, 1'b0);
      change_setting(9, 2);
      send_run(20, 1'b1, 1'b0);
      change_setting(0, 0);
      send_run(4, 1'b0, 1'b0);
      change_setting(1, 4095);
      send_run(4, 1'b1, 1'b0);

      // Random small geometries with random content and occasional broken frames.
      // Each geometry opens a new frame so no line store entry is read unwritten.
      while (random_items < 100 || phase_idx < 4) begin
         w = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         n = w * h * $urandom_range(1, 2) + $urandom_range(0, w - 1);
         change_setting(w, h);
         if (phase_idx == 1) begin
            // Results back up behind the stalled receiver until the input stalls.
            long_hold_req = 1'b1;
         end
         if (phase_idx == 3) begin
            send_run(n / 2, 1'b1, 1'b1);
            drain_pipeline();
            send_run(n - n / 2, 1'b0, 1'b1);
         end else begin
            send_run(n, 1'b1, 1'b1);
         end
         random_items += n;
         phase_idx++;
         if (random_items >= 70) begin
            idle_on = 1'b0;
         end
      end

      drain_pipeline();
      $display("Covered %0d pixels over %0d frame geometries, from frames with no interior",
               blur_check.pixels_seen, geometries);
      $display("to 3x3 corner copies and random small frames; %0d results compared, %0d mismatches.",
               blur_check.results_checked, blur_check.mismatches);
      if (blur_check.mismatches == 0 && blur_check.pending() == 0) begin
         $display("[box_blur_3x3_replicate_border_core] OK");
      end else begin
         $display("[box_blur_3x3_replicate_border_core] ERROR");
      end
      $finish;
   end

endmodule
